// File: src/pcsd_pkg.sv
package pcsd_pkg;

  // item kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_FEED_FORWARD   = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_ZONE  = 3'd4;
  localparam logic [2:0] REG_SETTLE_ZONE    = 3'd5;
  localparam logic [2:0] REG_RUN_TIMEOUT    = 3'd6;
  localparam logic [2:0] REG_SETTLE_TIMEOUT = 3'd7;

  localparam int          ADDR_W    = 5;
  localparam logic [19:0] TIMER_MAX = 20'hFFFFF;
  localparam logic [15:0] GAIN_P_RESET = 16'd256;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] target;
    logic signed [15:0] feedback;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               completed;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [31:0] feed_forward;
    logic [15:0]        integral_zone;
    logic [15:0]        settle_zone;
    logic [19:0]        run_timeout;
    logic [19:0]        settle_timeout;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:         GAIN_P_RESET,
    gain_i:         16'sd0,
    gain_d:         16'sd0,
    feed_forward:   32'sd0,
    integral_zone:  16'd0,
    settle_zone:    16'd0,
    run_timeout:    20'd0,
    settle_timeout: 20'd0
  };

endpackage

// File: src/pcsd_regs.sv
module pcsd_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcsd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pcsd_pkg::cfg_t               cfg
);

  pcsd_pkg::cfg_t cfg_r;
  pcsd_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        pcsd_pkg::REG_GAIN_P:         cfg_nxt.gain_p         = pwdata[15:0];
        pcsd_pkg::REG_GAIN_I:         cfg_nxt.gain_i         = pwdata[15:0];
        pcsd_pkg::REG_GAIN_D:         cfg_nxt.gain_d         = pwdata[15:0];
        pcsd_pkg::REG_FEED_FORWARD:   cfg_nxt.feed_forward   = pwdata;
        pcsd_pkg::REG_INTEGRAL_ZONE:  cfg_nxt.integral_zone  = pwdata[15:0];
        pcsd_pkg::REG_SETTLE_ZONE:    cfg_nxt.settle_zone    = pwdata[15:0];
        pcsd_pkg::REG_RUN_TIMEOUT:    cfg_nxt.run_timeout    = pwdata[19:0];
        pcsd_pkg::REG_SETTLE_TIMEOUT: cfg_nxt.settle_timeout = pwdata[19:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pcsd_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      pcsd_pkg::REG_GAIN_P:         prdata = {16'd0, cfg_r.gain_p};
      pcsd_pkg::REG_GAIN_I:         prdata = {16'd0, cfg_r.gain_i};
      pcsd_pkg::REG_GAIN_D:         prdata = {16'd0, cfg_r.gain_d};
      pcsd_pkg::REG_FEED_FORWARD:   prdata = cfg_r.feed_forward;
      pcsd_pkg::REG_INTEGRAL_ZONE:  prdata = {16'd0, cfg_r.integral_zone};
      pcsd_pkg::REG_SETTLE_ZONE:    prdata = {16'd0, cfg_r.settle_zone};
      pcsd_pkg::REG_RUN_TIMEOUT:    prdata = {12'd0, cfg_r.run_timeout};
      pcsd_pkg::REG_SETTLE_TIMEOUT: prdata = {12'd0, cfg_r.settle_timeout};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// File: src/pcsd_core.sv
module pcsd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  pcsd_pkg::in_item_t   item,
  input  pcsd_pkg::cfg_t       cfg,
  output pcsd_pkg::out_item_t  res
);

  logic signed [15:0] last_error_r, last_error_nxt;
  logic signed [31:0] error_sum_r, error_sum_nxt;
  logic [19:0]        run_ticks_r, run_ticks_nxt;
  logic [19:0]        settled_ticks_r, settled_ticks_nxt;

  logic signed [16:0] diff;
  logic signed [15:0] e;
  logic signed [16:0] e_ext;
  logic signed [16:0] d;
  logic [16:0]        mag;
  logic               in_zone;
  logic               flip;
  logic signed [32:0] sum_ext;
  logic signed [31:0] sum_sat;
  logic signed [31:0] sum_new;
  logic signed [31:0] prod_p;
  logic signed [32:0] prod_d;
  logic signed [47:0] prod_i;
  logic signed [49:0] acc;
  logic signed [41:0] acc_shr;
  logic signed [42:0] with_ff;
  logic signed [31:0] drive_s;

  // error path
  always_comb begin
    diff = $signed({item.target[15], item.target}) - $signed({item.feedback[15], item.feedback});
    if (diff > 17'sd32767)
      e = 16'sh7FFF;
    else if (diff < -17'sd32768)
      e = 16'sh8000;
    else
      e = diff[15:0];
    e_ext = $signed({e[15], e});
    mag   = e[15] ? 17'(-e_ext) : e_ext;
    d     = $signed({last_error_r[15], last_error_r}) - e_ext;

    in_zone = mag < {1'b0, cfg.integral_zone};
    // strict sign change between previous and current error
    flip = ((!e[15] && (e != 16'sd0)) && last_error_r[15]) ||
           (e[15] && (!last_error_r[15] && (last_error_r != 16'sd0)));

    sum_ext = $signed({error_sum_r[31], error_sum_r}) + 33'(e);
    if (sum_ext[32] != sum_ext[31])
      sum_sat = sum_ext[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else
      sum_sat = sum_ext[31:0];
    sum_new = (in_zone && !flip) ? sum_sat : 32'sd0;
  end

  // drive path
  always_comb begin
    prod_p  = cfg.gain_p * e;
    prod_d  = cfg.gain_d * d;
    prod_i  = cfg.gain_i * sum_new;
    acc     = 50'(prod_p) + 50'(prod_d) + 50'(prod_i);
    acc_shr = acc[49:8];
    with_ff = 43'(acc_shr) + 43'(cfg.feed_forward);
    if (with_ff > 43'sd2147483647)
      drive_s = 32'sh7FFFFFFF;
    else if (with_ff < -43'sd2147483648)
      drive_s = 32'sh80000000;
    else
      drive_s = with_ff[31:0];
  end

  always_comb begin
    last_error_nxt    = last_error_r;
    error_sum_nxt     = error_sum_r;
    run_ticks_nxt     = run_ticks_r;
    settled_ticks_nxt = settled_ticks_r;
    res.drive         = 32'sd0;
    case (item.kind)
      pcsd_pkg::KIND_SAMPLE: begin
        last_error_nxt = e;
        error_sum_nxt  = sum_new;
        if (mag > {1'b0, cfg.settle_zone})
          settled_ticks_nxt = 20'd0;
        res.drive = drive_s;
      end
      pcsd_pkg::KIND_TICK: begin
        if (run_ticks_r != pcsd_pkg::TIMER_MAX)
          run_ticks_nxt = run_ticks_r + 20'd1;
        if (settled_ticks_r != pcsd_pkg::TIMER_MAX)
          settled_ticks_nxt = settled_ticks_r + 20'd1;
      end
      pcsd_pkg::KIND_RESTART: begin
        last_error_nxt    = 16'sd0;
        error_sum_nxt     = 32'sd0;
        run_ticks_nxt     = 20'd0;
        settled_ticks_nxt = 20'd0;
      end
      default: begin
      end
    endcase
    // completion uses the timers after this item's update
    res.completed = ((cfg.run_timeout != 20'd0) && (run_ticks_nxt > cfg.run_timeout)) ||
                    ((cfg.settle_timeout != 20'd0) &&
                     (settled_ticks_nxt > cfg.settle_timeout));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r    <= '0;
      error_sum_r     <= '0;
      run_ticks_r     <= '0;
      settled_ticks_r <= '0;
    end else if (fire) begin
      last_error_r    <= last_error_nxt;
      error_sum_r     <= error_sum_nxt;
      run_ticks_r     <= run_ticks_nxt;
      settled_ticks_r <= settled_ticks_nxt;
    end
  end

endmodule

// File: src/pid_controller_with_settle_detect_top.sv
// PID controller with integral zone, feedforward and settle/run timeouts. Every item
// (sample, tick, restart or other kind) gives one result. Items are taken one per clock
// when the result side keeps up; an accepted item waits in the input register while one
// combinational pass through the error, integral and three multipliers feeds the result
// register. A stalled result holds the input register, so at most two items are inside.
// Gains and limits are set over the APB port; the user must set them only while idle,
// and the block itself does not enforce it.
module pid_controller_with_settle_detect_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pcsd_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pcsd_pkg::out_item_t          out_item,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pcsd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  pcsd_pkg::cfg_t      cfg;
  pcsd_pkg::out_item_t res;

  logic                in_valid_r, in_valid_nxt;
  pcsd_pkg::in_item_t  in_item_r, in_item_nxt;
  logic                out_valid_r, out_valid_nxt;
  pcsd_pkg::out_item_t out_item_r, out_item_nxt;
  logic                adv;
  logic                fire;
  logic                in_take;

  pcsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pcsd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register frees up when empty or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_item_nxt   = in_item_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = in_valid_r;
      if (fire)
        out_item_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: src/pcsd_checker.sv
module pcsd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input pcsd_pkg::in_item_t           in_item,
  input logic                         out_valid,
  input logic                         out_stall,
  input pcsd_pkg::out_item_t          out_item
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // a restart taken into an empty block with no result stall behind it comes out cleared
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_item.kind == pcsd_pkg::KIND_RESTART) && !out_valid)
      ##1 !out_stall
    |=> out_valid && (out_item.drive == 32'sd0) && !out_item.completed)
    else $error("restart result not cleared");

endmodule

bind pid_controller_with_settle_detect_top pcsd_checker u_pcsd_checker (.*);

// File: tb/tb_top.sv
module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint     I32_MAX     = 64'sd2147483647;
  localparam longint     I32_MIN     = -64'sd2147483648;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pcsd_pkg::in_item_t   in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pcsd_pkg::out_item_t  out_item;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [pcsd_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]          cfg_pwdata = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  pid_controller_with_settle_detect_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller model state and register shadow
  pcsd_pkg::cfg_t     regs_sh;
  logic signed [15:0] prev_err;
  logic signed [31:0] integ;
  logic [19:0]        run_cnt;
  logic [19:0]        settle_cnt;

  pcsd_pkg::out_item_t pending_results[$];

  int       n_errors = 0;
  int       n_items = 0;
  int       n_samples = 0;
  int       n_ticks = 0;
  int       n_results = 0;
  int       n_completed = 0;
  int       n_cfg_loads = 0;
  int       burst_left = 0;
  int       gap_max = 0;
  int       hold_cycles = 0;
  rx_mode_t stall_mode = RX_FREE;

  function automatic pcsd_pkg::out_item_t pid_step(input pcsd_pkg::in_item_t it);
    pcsd_pkg::out_item_t res;
    int        e;
    int        d;
    int        mag;
    longint    s;
    longint    acc;
    res.drive = '0;
    if (it.kind == pcsd_pkg::KIND_SAMPLE) begin
      e = int'($signed(it.target)) - int'($signed(it.feedback));
      if (e > 32767) e = 32767;
      else if (e < -32768) e = -32768;
      d = int'(prev_err) - e;
      mag = (e < 0) ? -e : e;
      if (mag < int'(regs_sh.integral_zone)) begin
        s = longint'(integ) + e;
        if (s > I32_MAX) s = I32_MAX;
        else if (s < I32_MIN) s = I32_MIN;
        integ = s[31:0];
      end else begin
        integ = '0;
      end
      // strict sign flip against the previous error drops the integral
      if ((e > 0 && prev_err < 0) || (e < 0 && prev_err > 0)) integ = '0;
      if (mag > int'(regs_sh.settle_zone)) settle_cnt = '0;
      acc = longint'($signed(regs_sh.gain_p)) * e + longint'($signed(regs_sh.gain_d)) * d
            + longint'($signed(regs_sh.gain_i)) * longint'(integ);
      acc = (acc >>> 8) + longint'($signed(regs_sh.feed_forward));
      if (acc > I32_MAX) acc = I32_MAX;
      else if (acc < I32_MIN) acc = I32_MIN;
      res.drive = acc[31:0];
      prev_err = e[15:0];
    end else if (it.kind == pcsd_pkg::KIND_TICK) begin
      if (run_cnt != pcsd_pkg::TIMER_MAX) run_cnt++;
      if (settle_cnt != pcsd_pkg::TIMER_MAX) settle_cnt++;
    end else if (it.kind == pcsd_pkg::KIND_RESTART) begin
      prev_err = '0;
      integ = '0;
      run_cnt = '0;
      settle_cnt = '0;
    end
    res.completed = (regs_sh.run_timeout != '0 && run_cnt > regs_sh.run_timeout) ||
                    (regs_sh.settle_timeout != '0 && settle_cnt > regs_sh.settle_timeout);
    return res;
  endfunction

  function automatic pcsd_pkg::in_item_t mk_item(input logic [1:0] k, input logic [15:0] t,
                                                 input logic [15:0] f);
    pcsd_pkg::in_item_t it;
    it.kind = k;
    it.target = t;
    it.feedback = f;
    return it;
  endfunction

  function automatic pcsd_pkg::in_item_t rand_item(input bit near);
    pcsd_pkg::in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    it.target = 16'($urandom);
    it.feedback = 16'($urandom);
    if (r < 72) it.kind = pcsd_pkg::KIND_SAMPLE;
    else if (r < 96) it.kind = pcsd_pkg::KIND_TICK;
    else if (r < 98) it.kind = pcsd_pkg::KIND_RESTART;
    else it.kind = KIND_UNUSED;
    // keep most errors small so zones and the integral see action
    if (it.kind == pcsd_pkg::KIND_SAMPLE && near && $urandom_range(0, 3) != 0)
      it.feedback = it.target - 16'($urandom_range(0, 600)) + 16'd300;
    if (it.kind == pcsd_pkg::KIND_SAMPLE && $urandom_range(0, 9) == 0) it.feedback = '0;
    return it;
  endfunction

  function automatic pcsd_pkg::cfg_t pick_config(input int style);
    pcsd_pkg::cfg_t c;
    case (style)
      1: begin
        c.gain_p = 16'sh7FFF; c.gain_i = 16'sh7FFF; c.gain_d = 16'sh7FFF;
        c.feed_forward = 32'sh7FFFFFFF;
        c.integral_zone = 16'hFFFF; c.settle_zone = 16'hFFFF;
        c.run_timeout = pcsd_pkg::TIMER_MAX; c.settle_timeout = pcsd_pkg::TIMER_MAX;
      end
      2: begin
        c.gain_p = 16'sh8000; c.gain_i = 16'sh8000; c.gain_d = 16'sh8000;
        c.feed_forward = 32'sh80000000;
        c.integral_zone = '0; c.settle_zone = '0;
        c.run_timeout = '0; c.settle_timeout = '0;
      end
      3: begin
        c.gain_p = 16'($urandom); c.gain_i = 16'($urandom); c.gain_d = 16'($urandom);
        c.feed_forward = 32'($urandom);
        c.integral_zone = 16'($urandom); c.settle_zone = 16'($urandom);
        c.run_timeout = 20'($urandom_range(0, 30)); c.settle_timeout = 20'($urandom);
      end
      default: begin
        c.gain_p = 16'($urandom_range(0, 1024)) - 16'd512;
        c.gain_i = 16'($urandom_range(0, 128)) - 16'd64;
        c.gain_d = 16'($urandom_range(0, 1024)) - 16'd512;
        c.feed_forward = 32'($urandom_range(0, 200000)) - 32'd100000;
        c.integral_zone = 16'($urandom_range(0, 400));
        c.settle_zone = 16'($urandom_range(0, 300));
        c.run_timeout = 20'($urandom_range(0, 20));
        c.settle_timeout = 20'($urandom_range(0, 10));
      end
    endcase
    return c;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      pcsd_pkg::REG_GAIN_P:         regs_sh.gain_p = value[15:0];
      pcsd_pkg::REG_GAIN_I:         regs_sh.gain_i = value[15:0];
      pcsd_pkg::REG_GAIN_D:         regs_sh.gain_d = value[15:0];
      pcsd_pkg::REG_FEED_FORWARD:   regs_sh.feed_forward = value;
      pcsd_pkg::REG_INTEGRAL_ZONE:  regs_sh.integral_zone = value[15:0];
      pcsd_pkg::REG_SETTLE_ZONE:    regs_sh.settle_zone = value[15:0];
      pcsd_pkg::REG_RUN_TIMEOUT:    regs_sh.run_timeout = value[19:0];
      pcsd_pkg::REG_SETTLE_TIMEOUT: regs_sh.settle_timeout = value[19:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk; the block must drop them
  task automatic load_config(input pcsd_pkg::cfg_t c);
    apb_write(pcsd_pkg::REG_GAIN_P, {16'($urandom), c.gain_p});
    apb_write(pcsd_pkg::REG_GAIN_I, {16'($urandom), c.gain_i});
    apb_write(pcsd_pkg::REG_GAIN_D, {16'($urandom), c.gain_d});
    apb_write(pcsd_pkg::REG_FEED_FORWARD, c.feed_forward);
    apb_write(pcsd_pkg::REG_INTEGRAL_ZONE, {16'($urandom), c.integral_zone});
    apb_write(pcsd_pkg::REG_SETTLE_ZONE, {16'($urandom), c.settle_zone});
    apb_write(pcsd_pkg::REG_RUN_TIMEOUT, {12'($urandom), c.run_timeout});
    apb_write(pcsd_pkg::REG_SETTLE_TIMEOUT, {12'($urandom), c.settle_timeout});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    n_cfg_loads++;
  endtask

  task automatic send_item(input pcsd_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(pid_step(it));
    n_items++;
    if (it.kind == pcsd_pkg::KIND_SAMPLE) n_samples++;
    if (it.kind == pcsd_pkg::KIND_TICK) n_ticks++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int gmax, input rx_mode_t mode);
    gap_max = gmax;
    stall_mode = mode;
  endtask

  task automatic test_reset_defaults();
    set_idling(2, RX_LIGHT);
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd1234, 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h8000, 16'h7FFF));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h7FFF, 16'h8000));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd0, 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF));
    wait_results_done();
  endtask

  task automatic test_directed_cases();
    pcsd_pkg::cfg_t c;
    c.gain_p = 16'sd256; c.gain_i = 16'sd16; c.gain_d = -16'sd64;
    c.feed_forward = 32'sd1000;
    c.integral_zone = 16'd100; c.settle_zone = 16'd50;
    c.run_timeout = 20'd3; c.settle_timeout = 20'd2;
    load_config(c);
    set_idling(0, RX_FREE);
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h7FFF, 16'h8000));   // error clips high
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h8000, 16'h7FFF));   // clips low, sign flip
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd0, 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd10, 16'd0));        // direct error, in zone
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd20, 16'd5));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, -16'sd5, 16'd0));  // sign flip clears integral
    send_item(mk_item(KIND_UNUSED, 16'h5A5A, 16'hA5A5));
    send_item(mk_item(pcsd_pkg::KIND_TICK, 16'h7FFF, 16'h8000));
    send_item(mk_item(pcsd_pkg::KIND_TICK, 16'd0, 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_TICK, 16'd0, 16'd0));      // settle and run timers pass limit
    send_item(mk_item(pcsd_pkg::KIND_TICK, 16'd0, 16'd0));      // both timers stay past limit
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd60, 16'd0));   // outside settle zone
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd50, 16'd0));   // on the settle edge
    send_item(mk_item(pcsd_pkg::KIND_RESTART, 16'hFFFF, 16'h1234));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h7FFF, 16'h7FFF));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h8000, 16'h8000));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd100, 16'd0));  // on the integral edge
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd99, 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd99, 16'd0));
    wait_results_done();
  endtask

  task automatic test_config_sweep();
    int       styles[6] = '{0, 1, 2, 3, 0, 3};
    int       gaps[6] = '{0, 3, 8, 1, 0, 5};
    rx_mode_t modes[6] = '{RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN, RX_LIGHT, RX_FREE};
    for (int ph = 0; ph < 6; ph++) begin
      load_config(pick_config(styles[ph]));
      set_idling(gaps[ph], modes[ph]);
      for (int i = 0; i < 100; i++)
        send_item(rand_item(styles[ph] == 0 || $urandom_range(0, 1) == 1));
      wait_results_done();
    end
  endtask

  task automatic test_backpressure();
    load_config(pick_config(0));
    set_idling(0, RX_FREE);
    hold_cycles = 50;
    for (int i = 0; i < 30; i++) send_item(rand_item(1));
    // sender holds until the pipe is empty, then resumes
    wait_results_done();
    set_idling(4, RX_HEAVY);
    for (int i = 0; i < 20; i++) send_item(rand_item(1));
    wait_results_done();
  endtask

  // full-scale errors pile up in the integral, then a sign flip drops it
  task automatic test_integral_saturation();
    pcsd_pkg::cfg_t c;
    c = '0;
    c.gain_i = 16'sd256;
    c.integral_zone = 16'hFFFF;
    c.settle_zone = 16'hFFFF;
    load_config(c);
    set_idling(0, RX_FREE);
    send_item(mk_item(pcsd_pkg::KIND_RESTART, 16'd0, 16'd0));
    for (int i = 0; i < 20; i++)
      send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h7FFF, 16'h8000));
    for (int i = 0; i < 20; i++)
      send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'h8000, 16'h7FFF));
    wait_results_done();
  endtask

  // a timeout at the timer ceiling stays quiet; a short one fires
  task automatic test_timer_saturation();
    pcsd_pkg::cfg_t c;
    c = '0;
    c.gain_p = 16'sd256;
    c.settle_zone = 16'hFFFF;
    c.run_timeout = pcsd_pkg::TIMER_MAX;
    c.settle_timeout = 20'd3;
    load_config(c);
    set_idling(0, RX_FREE);
    send_item(mk_item(pcsd_pkg::KIND_RESTART, 16'd0, 16'd0));
    for (int i = 0; i < 10; i++)
      send_item(mk_item(pcsd_pkg::KIND_TICK, 16'($urandom), 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_SAMPLE, 16'd300, 16'd0));
    send_item(mk_item(pcsd_pkg::KIND_RESTART, 16'd0, 16'd0));
    wait_results_done();
  endtask

  initial begin : result_stall_gen
    int n;
    int k;
    k = 0;
    forever begin
      @(posedge clk);
      k++;
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        case (stall_mode)
          RX_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_stall <= ((k % 9) < 4);
          default:    out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    pcsd_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      n_results++;
      if (out_item.completed === 1'b1) n_completed++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors < 30)
          $display("%0t: unexpected result: drive %0d completed %0b", $time,
                   $signed(out_item.drive), out_item.completed);
      end else begin
        want = pending_results.pop_front();
        if (out_item.drive !== want.drive) begin
          n_errors++;
          if (n_errors < 30)
            $display("%0t: drive mismatch: expected %0d, actual %0d", $time,
                     $signed(want.drive), $signed(out_item.drive));
        end
        if (out_item.completed !== want.completed) begin
          n_errors++;
          if (n_errors < 30)
            $display("%0t: completed mismatch: expected %0b, actual %0b", $time,
                     want.completed, out_item.completed);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL pid_controller_with_settle_detect_top");
    $finish;
  end

  initial begin
    regs_sh = '0;
    regs_sh.gain_p = pcsd_pkg::GAIN_P_RESET;
    prev_err = '0;
    integ = '0;
    run_cnt = '0;
    settle_cnt = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_config_sweep();
    test_backpressure();
    test_integral_saturation();
    test_timer_saturation();
    wait_results_done();
    repeat (8) @(posedge clk);
    $display("Covered %0d items (%0d samples, %0d ticks) over %0d register loads;",
             n_items, n_samples, n_ticks, n_cfg_loads);
    $display("%0d results checked, %0d flagged complete, %0d errors.",
             n_results, n_completed, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("PASS pid_controller_with_settle_detect_top");
    end else begin
      $display("FAIL pid_controller_with_settle_detect_top");
    end
    $finish;
  end

endmodule

// File: files.f
src/pcsd_pkg.sv
src/pcsd_regs.sv
src/pcsd_core.sv
src/pid_controller_with_settle_detect_top.sv
src/pcsd_checker.sv
tb/tb_top.sv
